FILE: src/ypd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ypd_pkg;

    // Fixed field widths of the block.
    localparam int DELTA_BITS    = 16;
    localparam int SENS_BITS     = 16;
    localparam int PITCH_BITS    = 24;
    localparam int REJECT_BITS   = 15;
    localparam int CFG_ADDR_BITS = 4;

    // Register map, one 32-bit word per register.
    typedef enum logic [1:0] {
        REG_SENS   = 2'd0,
        REG_PMIN   = 2'd1,
        REG_PMAX   = 2'd2,
        REG_REJECT = 2'd3
    } t_reg_idx;

    // Register reset values.
    localparam logic [SENS_BITS-1:0]          SENS_RESET   = 16'd3728;
    localparam logic signed [PITCH_BITS-1:0]  PMIN_RESET   = -24'sd3728270;
    localparam logic signed [PITCH_BITS-1:0]  PMAX_RESET   = 24'sd3728270;
    localparam logic [REJECT_BITS-1:0]        REJECT_RESET = 15'd500;

    // CORDIC constants: Q2.30 values, angles in 2^-32 turn.
    localparam int                 CORDIC_STEPS    = 30;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic [31:0]        EIGHTH_TURN     = 32'h2000_0000;

    // Request to the shared CORDIC unit.
    typedef struct packed {
        logic        start;
        logic [31:0] turn;
    } t_cordic_req;

    // Result of the shared CORDIC unit, valid while done is high.
    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } t_cordic_res;

    // Arctangent of 2^-i in 2^-32 turn units.
    function automatic logic signed [31:0] f_atan_turn32(input logic [4:0] idx);
        case (idx)
            5'd0:    return 32'sd536870912;
            5'd1:    return 32'sd316933406;
            5'd2:    return 32'sd167458907;
            5'd3:    return 32'sd85004756;
            5'd4:    return 32'sd42667331;
            5'd5:    return 32'sd21354465;
            5'd6:    return 32'sd10679838;
            5'd7:    return 32'sd5340245;
            5'd8:    return 32'sd2670163;
            5'd9:    return 32'sd1335087;
            5'd10:   return 32'sd667544;
            5'd11:   return 32'sd333772;
            5'd12:   return 32'sd166886;
            5'd13:   return 32'sd83443;
            5'd14:   return 32'sd41722;
            5'd15:   return 32'sd20861;
            5'd16:   return 32'sd10430;
            5'd17:   return 32'sd5215;
            5'd18:   return 32'sd2608;
            5'd19:   return 32'sd1304;
            5'd20:   return 32'sd652;
            5'd21:   return 32'sd326;
            5'd22:   return 32'sd163;
            5'd23:   return 32'sd81;
            5'd24:   return 32'sd41;
            5'd25:   return 32'sd20;
            5'd26:   return 32'sd10;
            5'd27:   return 32'sd5;
            5'd28:   return 32'sd3;
            5'd29:   return 32'sd1;
            default: return 32'sd0;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: src/ypd_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module ypd_cordic
    import ypd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cordic_req  i_req,
    output t_cordic_res       o_res
);

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic [1:0]         r_quad;
    logic [4:0]         r_step;
    logic               r_run;
    logic               r_done;

    logic [31:0]        w_rounded;
    logic [1:0]         w_quad;
    logic [31:0]        w_resid;
    logic signed [31:0] w_xs;
    logic signed [31:0] w_ys;
    logic signed [31:0] w_atan;

    // Nearest quadrant and the residue left within one eighth of a turn.
    assign w_rounded = i_req.turn + EIGHTH_TURN;
    assign w_quad    = w_rounded[31:30];
    assign w_resid   = i_req.turn - {w_quad, 30'd0};

    // One rotation step per cycle through a shared shifter pair.
    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;
    assign w_atan = f_atan_turn32(r_step);

    // Step sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                if (r_step == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 5'd1;
            end
        end
    end

    // Rotation datapath.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= signed'(w_resid);
            r_quad <= w_quad;
        end else if (r_run) begin
            if (!r_z[31]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end
        end
    end

    // Put the quadrant back exactly.
    always_comb begin
        o_res.done = r_done;
        if (r_quad[0]) begin
            o_res.cos_v = r_quad[1] ? r_y : -r_y;
            o_res.sin_v = r_quad[1] ? -r_x : r_x;
        end else begin
            o_res.cos_v = r_quad[1] ? -r_x : r_x;
            o_res.sin_v = r_quad[1] ? -r_y : r_y;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("CORDIC reports done while still rotating");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_run)
        else $error("CORDIC restarted in the middle of a rotation");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && r_step == LAST_STEP && !i_req.start) |=> r_done)
        else $error("CORDIC last step did not raise done");

endmodule

`default_nettype wire

FILE: src/yaw_pitch_direction_update.sv
`timescale 1ns / 1ps
`default_nettype none

// Mouse-look direction unit. Each input item carries a signed pointer delta
// pair; each item gives one result item with both angles, the forward vector
// and the right vector (Q1.(VECTOR_BITS-1)) and an accepted flag.
// Input and output channels use valid and stall; an item moves on a rising
// edge where valid is high and stall is low. The APB port (pready always
// high) holds sensitivity, pitch bounds and the vertical reject limit.
// One item is in work at a time. From the accepting edge the result passes
// through bit-serial delta product, an angle update, two passes of one
// shared 30-step CORDIC unit (yaw, then pitch), bit-serial vector products
// and output rounding before it shows on the output. The next item is taken
// at the end of the cycle in which the result shows. Reset sets yaw and
// pitch to zero, the registers to their defaults and empties the output
// register. When the receiver stalls, the result holds in the output
// register and the block keeps taking and working on the next item; it
// waits in its last cycle only if that next result is ready before the
// previous one has been taken.
module yaw_pitch_direction_update
    import ypd_pkg::*;
#(
    parameter int ANGLE_BITS  = 24,
    parameter int VECTOR_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0]      paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [DELTA_BITS-1:0]  i_delta_x,
    input  wire logic signed [DELTA_BITS-1:0]  i_delta_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_accepted,
    output logic [ANGLE_BITS-1:0]              o_yaw_out,
    output logic signed [PITCH_BITS-1:0]       o_pitch_out,
    output logic signed [VECTOR_BITS-1:0]      o_forward_x,
    output logic signed [VECTOR_BITS-1:0]      o_forward_y,
    output logic signed [VECTOR_BITS-1:0]      o_forward_z,
    output logic signed [VECTOR_BITS-1:0]      o_right_x,
    output logic signed [VECTOR_BITS-1:0]      o_right_z
);

    localparam int TURN_SHIFT = 32 - ANGLE_BITS;
    localparam int SHIFT_ONE  = 31 - VECTOR_BITS;
    localparam int SHIFT_TWO  = 61 - VECTOR_BITS;
    localparam int PROD_BITS  = 65;
    localparam logic signed [PROD_BITS-1:0] PROD_ONE = PROD_BITS'(1);
    localparam logic signed [PROD_BITS-1:0] VEC_TOP  =
        (PROD_ONE <<< (VECTOR_BITS - 1)) - PROD_ONE;
    localparam logic signed [PROD_BITS-1:0] VEC_BOT  = -VEC_TOP - PROD_ONE;
    localparam logic [4:0] MULD_LAST = 5'(SENS_BITS - 1);
    localparam logic [4:0] MULV_LAST = 5'(32 - 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MULD = 7'b0000010,
        ST_UPD  = 7'b0000100,
        ST_CORY = 7'b0001000,
        ST_CORP = 7'b0010000,
        ST_MULV = 7'b0100000,
        ST_FIN  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [SENS_BITS-1:0]          r_sens;
    logic signed [PITCH_BITS-1:0]  r_pmin;
    logic signed [PITCH_BITS-1:0]  r_pmax;
    logic [REJECT_BITS-1:0]        r_reject;

    // Angle state.
    logic [ANGLE_BITS-1:0]         r_yaw;
    logic signed [PITCH_BITS-1:0]  r_pitch;
    logic [ANGLE_BITS-1:0]         n_yaw;
    logic signed [PITCH_BITS-1:0]  n_pitch;

    // Serial multiplier pair and operands.
    logic signed [31:0] r_mcand_a;
    logic signed [31:0] r_mcand_b;
    logic signed [32:0] r_hi_a;
    logic signed [32:0] r_hi_b;
    logic [31:0]        r_lo_a;
    logic [31:0]        r_lo_b;
    logic [4:0]         r_cnt;
    logic               r_ok;
    logic signed [31:0] r_sin_p;

    // Output register.
    logic                          r_out_valid;
    logic                          r_accepted;
    logic [ANGLE_BITS-1:0]         r_yaw_o;
    logic signed [PITCH_BITS-1:0]  r_pitch_o;
    logic signed [VECTOR_BITS-1:0] r_fwd_x;
    logic signed [VECTOR_BITS-1:0] r_fwd_y;
    logic signed [VECTOR_BITS-1:0] r_fwd_z;
    logic signed [VECTOR_BITS-1:0] r_rgt_x;
    logic signed [VECTOR_BITS-1:0] r_rgt_z;

    logic                   w_cfg_wr;
    logic                   w_in_acc;
    logic                   w_out_load;
    logic [DELTA_BITS:0]    w_abs_dy;
    logic                   w_mul_run;
    logic                   w_mul_last;
    logic                   w_sub;
    logic signed [33:0]     w_add_a;
    logic signed [33:0]     w_add_b;
    logic signed [33:0]     w_sum_a;
    logic signed [33:0]     w_sum_b;
    logic signed [31:0]     w_prod_x;
    logic signed [31:0]     w_prod_y;
    logic [ANGLE_BITS-1:0]  w_yaw_sum;
    logic signed [32:0]     w_pitch_wide;
    logic signed [32:0]     w_pitch_lo;
    logic signed [32:0]     w_pitch_hi;
    logic signed [32:0]     w_pitch_clamp;
    logic signed [PROD_BITS-1:0] w_prod_fx;
    logic signed [PROD_BITS-1:0] w_prod_fz;
    t_cordic_req            w_req;
    t_cordic_res            w_res;

    // Round to nearest at the given shift, then saturate to the vector range.
    function automatic logic signed [VECTOR_BITS-1:0] f_to_vec(
        input logic signed [PROD_BITS-1:0] v,
        input int                          shift
    );
        logic signed [PROD_BITS-1:0] t;
        logic signed [PROD_BITS-1:0] r;
        t = v >>> (shift - 1);
        r = (t + PROD_ONE) >>> 1;
        if (r > VEC_TOP) begin
            return VEC_TOP[VECTOR_BITS-1:0];
        end else if (r < VEC_BOT) begin
            return VEC_BOT[VECTOR_BITS-1:0];
        end
        return r[VECTOR_BITS-1:0];
    endfunction

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens   <= SENS_RESET;
            r_pmin   <= PMIN_RESET;
            r_pmax   <= PMAX_RESET;
            r_reject <= REJECT_RESET;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_SENS:   r_sens   <= pwdata[SENS_BITS-1:0];
                REG_PMIN:   r_pmin   <= pwdata[PITCH_BITS-1:0];
                REG_PMAX:   r_pmax   <= pwdata[PITCH_BITS-1:0];
                REG_REJECT: r_reject <= pwdata[REJECT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_SENS:   prdata = {{(32-SENS_BITS){1'b0}}, r_sens};
            REG_PMIN:   prdata = {{(32-PITCH_BITS){1'b0}}, r_pmin};
            REG_PMAX:   prdata = {{(32-PITCH_BITS){1'b0}}, r_pmax};
            REG_REJECT: prdata = {{(32-REJECT_BITS){1'b0}}, r_reject};
            default:    prdata = '0;
        endcase
    end

    // Channel handshakes.
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    // Magnitude of the vertical delta for the reject test.
    assign w_abs_dy = i_delta_y[DELTA_BITS-1] ?
        ((DELTA_BITS + 1)'(0) - (DELTA_BITS + 1)'(i_delta_y)) :
        (DELTA_BITS + 1)'(i_delta_y);

    // Shift-add multiplier step, one multiplier bit per cycle. The last bit of
    // a signed multiplier carries negative weight.
    assign w_mul_run  = (r_state == ST_MULD) || (r_state == ST_MULV);
    assign w_mul_last = (r_state == ST_MULD) ? (r_cnt == MULD_LAST) : (r_cnt == MULV_LAST);
    assign w_sub      = (r_state == ST_MULV) && (r_cnt == MULV_LAST);
    assign w_add_a    = r_lo_a[0] ? 34'(r_mcand_a) : '0;
    assign w_add_b    = r_lo_b[0] ? 34'(r_mcand_b) : '0;
    assign w_sum_a    = w_sub ? (34'(r_hi_a) - w_add_a) : (34'(r_hi_a) + w_add_a);
    assign w_sum_b    = w_sub ? (34'(r_hi_b) - w_add_b) : (34'(r_hi_b) + w_add_b);

    // Delta products after the short pass; vector products after the long one.
    assign w_prod_x  = {r_hi_a[SENS_BITS-1:0], r_lo_a[31:32-SENS_BITS]};
    assign w_prod_y  = {r_hi_b[SENS_BITS-1:0], r_lo_b[31:32-SENS_BITS]};
    assign w_prod_fx = {r_hi_a, r_lo_a};
    assign w_prod_fz = {r_hi_b, r_lo_b};

    // Angle update: yaw wraps, pitch is clamped low bound first.
    assign w_yaw_sum    = r_yaw + w_prod_x[ANGLE_BITS-1:0];
    assign w_pitch_wide = 33'(r_pitch) - 33'(w_prod_y);
    assign w_pitch_lo   = 33'(r_pmin);
    assign w_pitch_hi   = 33'(r_pmax);

    always_comb begin
        w_pitch_clamp = w_pitch_wide;
        if (w_pitch_clamp < w_pitch_lo) begin
            w_pitch_clamp = w_pitch_lo;
        end
        if (w_pitch_clamp > w_pitch_hi) begin
            w_pitch_clamp = w_pitch_hi;
        end
    end

    assign n_yaw   = r_ok ? w_yaw_sum : r_yaw;
    assign n_pitch = r_ok ? PITCH_BITS'(w_pitch_clamp) : r_pitch;

    // CORDIC requests: yaw after the update, pitch once yaw is done.
    always_comb begin
        w_req.start = 1'b0;
        w_req.turn  = 32'(r_yaw) << TURN_SHIFT;
        if (r_state == ST_UPD) begin
            w_req.start = 1'b1;
            w_req.turn  = 32'(n_yaw) << TURN_SHIFT;
        end else if (r_state == ST_CORY && w_res.done) begin
            w_req.start = 1'b1;
            w_req.turn  = 32'(r_pitch) << TURN_SHIFT;
        end
    end

    ypd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_MULD;
            ST_MULD: if (w_mul_last) n_state = ST_UPD;
            ST_UPD:  n_state = ST_CORY;
            ST_CORY: if (w_res.done) n_state = ST_CORP;
            ST_CORP: if (w_res.done) n_state = ST_MULV;
            ST_MULV: if (w_mul_last) n_state = ST_FIN;
            ST_FIN:  if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, angle state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_yaw       <= '0;
            r_pitch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (w_mul_run && !w_mul_last) ? (r_cnt + 5'd1) : '0;
            if (r_state == ST_UPD) begin
                r_yaw   <= n_yaw;
                r_pitch <= n_pitch;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mcand_a <= 32'(i_delta_x);
            r_mcand_b <= 32'(i_delta_y);
            r_hi_a    <= '0;
            r_hi_b    <= '0;
            r_lo_a    <= 32'(r_sens);
            r_lo_b    <= 32'(r_sens);
            r_ok      <= (w_abs_dy <= (DELTA_BITS + 1)'(r_reject));
        end
        if (w_mul_run) begin
            r_hi_a <= w_sum_a[33:1];
            r_hi_b <= w_sum_b[33:1];
            r_lo_a <= {w_sum_a[0], r_lo_a[31:1]};
            r_lo_b <= {w_sum_b[0], r_lo_b[31:1]};
        end
        // Keep sin and cos of yaw as the multiplicands for the vector pass.
        if (r_state == ST_CORY && w_res.done) begin
            r_mcand_a <= w_res.sin_v;
            r_mcand_b <= w_res.cos_v;
        end
        // Cosine of pitch is the shared multiplier of both products.
        if (r_state == ST_CORP && w_res.done) begin
            r_sin_p <= w_res.sin_v;
            r_hi_a  <= '0;
            r_hi_b  <= '0;
            r_lo_a  <= w_res.cos_v;
            r_lo_b  <= w_res.cos_v;
        end
        if (w_out_load) begin
            r_accepted <= r_ok;
            r_yaw_o    <= r_yaw;
            r_pitch_o  <= r_pitch;
            r_fwd_x    <= f_to_vec(w_prod_fx, SHIFT_TWO);
            r_fwd_y    <= f_to_vec(-(PROD_BITS'(r_sin_p)), SHIFT_ONE);
            r_fwd_z    <= f_to_vec(w_prod_fz, SHIFT_TWO);
            r_rgt_x    <= f_to_vec(PROD_BITS'(r_mcand_b), SHIFT_ONE);
            r_rgt_z    <= f_to_vec(-(PROD_BITS'(r_mcand_a)), SHIFT_ONE);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_yaw_out   = r_yaw_o;
    assign o_pitch_out = r_pitch_o;
    assign o_forward_x = r_fwd_x;
    assign o_forward_y = r_fwd_y;
    assign o_forward_z = r_fwd_z;
    assign o_right_x   = r_rgt_x;
    assign o_right_z   = r_rgt_z;

    a_acc_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == ST_MULD)
        else $error("Accepted item did not start the delta products");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == ST_UPD && r_ok) && $stable(r_pmin) && $stable(r_pmax)
            && r_pmin <= r_pmax)
        |-> (r_pitch >= r_pmin && r_pitch <= r_pmax))
        else $error("Updated pitch lies outside its bounds");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && i_out_stall) |=> r_state == ST_FIN)
        else $error("Result left the final step while the output was full");

    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_FIN))
        else $error("Output valid rose outside the final step");

endmodule

`default_nettype wire
